/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SAM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define SAM_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define SAM_ASSERT(label, clk, rstn, prop)
`define SAM_NEVER(label, clk, rstn, expr)
`endif
`endif

/* hw/rtl/sam_pkg.sv */
`default_nettype none
package sam_pkg;
    localparam int DATA_W = 32;
    localparam int OUT_W  = 48;

    typedef enum logic [2:0] {
        REG_CPX,
        REG_CPY,
        REG_CPZ,
        REG_CVX,
        REG_CVY,
        REG_CVZ,
        REG_RADIUS,
        REG_FILT
    } sam_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] vel_z;
        logic [DATA_W-1:0]        mass;
        logic                     last_particle;
    } sam_in_t;

    typedef struct packed {
        logic [OUT_W-1:0]  ang_mom_per_mass;
        logic [DATA_W-1:0] included_count;
        logic              no_mass;
    } sam_out_t;
endpackage
`default_nettype wire

/* hw/rtl/specific_angular_momentum_core.sv */
// per particle: one shared 32x32 multiplier, 16 products issued one per cycle, then the
//   final accumulate steps; s_ready returns once the particle is done
// last particle then adds the squared sum, the square root, the divide of a 64+FRAC_BITS
//   bit dividend and the load of the result register (only the load with no mass)
// a new particle is taken only once the previous one is done; a result still waiting in
//   the output register stalls the next result, and new requests with it
`default_nettype none
`include "assert_macros.svh"
module specific_angular_momentum_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sam_pkg::sam_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sam_pkg::sam_out_t      m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_wdata
);
    localparam int DVD_W = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W);
    localparam int OVF_STEPS = DVD_W - sam_pkg::OUT_W;
    localparam logic [64:0] HALF65 = 65'(1) << (FRAC_BITS - 1);
    localparam logic [96:0] HALF97 = 97'(1) << (FRAC_BITS - 1);
    localparam logic [63:0] INT_MAX = {1'b0, {63{1'b1}}};

    typedef enum logic [2:0] {ST_IDLE, ST_PART, ST_SQ, ST_ROOT, ST_DIV, ST_OUT} state_t;

    // configuration
    logic signed [31:0] cpos_reg [3];
    logic signed [31:0] cvel_reg [3];
    logic [31:0]        radius_reg;
    logic               filt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                cpos_reg[i] <= '0;
                cvel_reg[i] <= '0;
            end
            radius_reg <= '0;
            filt_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (sam_pkg::sam_reg_t'(cfg_index))
                sam_pkg::REG_CPX:    cpos_reg[0] <= cfg_wdata;
                sam_pkg::REG_CPY:    cpos_reg[1] <= cfg_wdata;
                sam_pkg::REG_CPZ:    cpos_reg[2] <= cfg_wdata;
                sam_pkg::REG_CVX:    cvel_reg[0] <= cfg_wdata;
                sam_pkg::REG_CVY:    cvel_reg[1] <= cfg_wdata;
                sam_pkg::REG_CVZ:    cvel_reg[2] <= cfg_wdata;
                sam_pkg::REG_RADIUS: radius_reg  <= cfg_wdata;
                sam_pkg::REG_FILT:   filt_reg    <= cfg_wdata[0];
                default:             filt_reg    <= filt_reg;
            endcase
        end
    end

    state_t             state_reg;
    logic [4:0]         step_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [31:0]        mag_reg [6];
    logic [5:0]         sgn_reg;
    logic [31:0]        mass_reg;
    logic               last_reg;
    logic [63:0]        prod_reg;
    logic               psgn_reg;
    logic [1:0]         psh_reg;
    logic [63:0]        d2_reg;
    logic               keep_reg;
    logic signed [63:0] cx_reg, cy_reg, cz_reg;
    logic [63:0]        lo_reg;
    logic signed [63:0] term_reg;
    logic signed [63:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [63:0]        sum_mass_reg;
    logic [31:0]        count_reg;
    logic [127:0]       sq_reg;
    logic [67:0]        rem_reg;
    logic [63:0]        root_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [63:0]        drem_reg;
    logic [47:0]        q_reg;
    logic               ovf_reg;
    logic               m_valid_reg;
    sam_pkg::sam_out_t  m_data_reg;

    // relative vectors at capture
    logic [31:0] cap_mag [6];
    logic [5:0]  cap_sgn;
    always_comb begin
        logic signed [31:0] pin [6];
        logic signed [31:0] cin [6];
        logic [32:0]        diff;
        pin[0] = s_data.pos_x; pin[1] = s_data.pos_y; pin[2] = s_data.pos_z;
        pin[3] = s_data.vel_x; pin[4] = s_data.vel_y; pin[5] = s_data.vel_z;
        cin[0] = cpos_reg[0];  cin[1] = cpos_reg[1];  cin[2] = cpos_reg[2];
        cin[3] = cvel_reg[0];  cin[4] = cvel_reg[1];  cin[5] = cvel_reg[2];
        for (int i = 0; i < 6; i++) begin
            diff       = {pin[i][31], pin[i]} - {cin[i][31], cin[i]};
            cap_sgn[i] = diff[32];
            cap_mag[i] = diff[32] ? 32'(-diff) : diff[31:0];
        end
    end

    // shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic        mul_sgn;
    logic        mul_issue;
    logic [63:0] cabs, labs;
    logic signed [63:0] csel, lsel;
    always_comb begin
        unique case (step_reg[3:1])
            3'd5:    csel = cx_reg;
            3'd6:    csel = cy_reg;
            default: csel = cz_reg;
        endcase
        cabs = csel[63] ? 64'(-csel) : 64'(csel);
        unique case (step_reg[3:2])
            2'd0:    lsel = sum_x_reg;
            2'd1:    lsel = sum_y_reg;
            default: lsel = sum_z_reg;
        endcase
        labs = lsel[63] ? 64'(-lsel) : 64'(lsel);
        mul_a   = '0;
        mul_b   = '0;
        mul_sgn = 1'b0;
        mul_issue = 1'b0;
        if (state_reg == ST_PART) begin
            mul_issue = (step_reg < 5'd16);
            unique case (step_reg)
                5'd0: begin mul_a = mag_reg[0]; mul_b = mag_reg[0]; end
                5'd1: begin mul_a = mag_reg[1]; mul_b = mag_reg[1]; end
                5'd2: begin mul_a = mag_reg[2]; mul_b = mag_reg[2]; end
                5'd3: begin mul_a = radius_reg; mul_b = radius_reg; end
                5'd4: begin
                    mul_a = mag_reg[1]; mul_b = mag_reg[5]; mul_sgn = sgn_reg[1] ^ sgn_reg[5];
                end
                5'd5: begin
                    mul_a = mag_reg[2]; mul_b = mag_reg[4]; mul_sgn = sgn_reg[2] ^ sgn_reg[4];
                end
                5'd6: begin
                    mul_a = mag_reg[2]; mul_b = mag_reg[3]; mul_sgn = sgn_reg[2] ^ sgn_reg[3];
                end
                5'd7: begin
                    mul_a = mag_reg[0]; mul_b = mag_reg[5]; mul_sgn = sgn_reg[0] ^ sgn_reg[5];
                end
                5'd8: begin
                    mul_a = mag_reg[0]; mul_b = mag_reg[4]; mul_sgn = sgn_reg[0] ^ sgn_reg[4];
                end
                5'd9: begin
                    mul_a = mag_reg[1]; mul_b = mag_reg[3]; mul_sgn = sgn_reg[1] ^ sgn_reg[3];
                end
                5'd10, 5'd12, 5'd14: begin mul_a = cabs[31:0];  mul_b = mass_reg; end
                5'd11, 5'd13, 5'd15: begin mul_a = cabs[63:32]; mul_b = mass_reg; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == ST_SQ) begin
            mul_issue = (step_reg < 5'd12);
            mul_a = step_reg[1] ? labs[63:32] : labs[31:0];
            mul_b = step_reg[0] ? labs[63:32] : labs[31:0];
        end
    end

    // rounded signed product of two differences
    logic [64:0]        rnd65;
    logic [63:0]        rnd;
    logic signed [63:0] pval;
    // rounded saturated cross component times mass
    logic [96:0]        full97;
    logic [96:0]        tsh;
    logic [63:0]        tmag;
    logic signed [63:0] tval;
    logic signed [63:0] tsrc;
    logic signed [63:0] asum_old, asum_new;
    logic signed [64:0] asum65;
    logic [64:0]        d2s65, ms65;
    logic [127:0]       sq_add;
    logic [67:0]        rnx, trial;
    logic               rge;
    logic [67:0]        rem_nx;
    logic [63:0]        root_nx;
    logic [64:0]        dr65;
    logic               dge;

    always_comb begin
        rnd65 = {1'b0, prod_reg} + HALF65;
        rnd   = 64'(rnd65 >> FRAC_BITS);
        pval  = psgn_reg ? -$signed(rnd) : $signed(rnd);

        unique case (step_reg[3:1])
            3'd6:    tsrc = cx_reg;
            3'd7:    tsrc = cy_reg;
            default: tsrc = cz_reg;
        endcase
        full97 = {1'b0, prod_reg, 32'b0} + {33'b0, lo_reg} + HALF97;
        tsh    = full97 >> FRAC_BITS;
        tmag   = (|tsh[96:63]) ? INT_MAX : {1'b0, tsh[62:0]};
        tval   = tsrc[63] ? -$signed(tmag) : $signed(tmag);

        unique case (step_reg)
            5'd13:   asum_old = sum_x_reg;
            5'd15:   asum_old = sum_y_reg;
            default: asum_old = sum_z_reg;
        endcase
        asum65 = {asum_old[63], asum_old} + {term_reg[63], term_reg};
        if (asum65[64] != asum65[63]) begin
            asum_new = asum65[64] ? {1'b1, 63'b0} : INT_MAX;
        end else begin
            asum_new = asum65[63:0];
        end

        d2s65 = {1'b0, d2_reg} + {1'b0, prod_reg};
        ms65  = {1'b0, sum_mass_reg} + {33'b0, mass_reg};

        unique case (psh_reg)
            2'd0:    sq_add = {64'b0, prod_reg};
            2'd3:    sq_add = {prod_reg, 64'b0};
            default: sq_add = {32'b0, prod_reg, 32'b0};
        endcase

        rnx     = {rem_reg[65:0], sq_reg[127:126]};
        trial   = {2'b0, root_reg, 2'b01};
        rge     = (rnx >= trial);
        rem_nx  = rge ? rnx - trial : rnx;
        root_nx = {root_reg[62:0], rge};

        dr65 = {drem_reg, dvd_reg[DVD_W-1]};
        dge  = (dr65 >= {1'b0, sum_mass_reg});
    end

    always_ff @(posedge aclk) begin
        if (mul_issue) begin
            prod_reg <= mul_a * mul_b;
            psgn_reg <= mul_sgn;
            psh_reg  <= step_reg[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            cnt_reg      <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_z_reg    <= '0;
            sum_mass_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        for (int i = 0; i < 6; i++) begin
                            mag_reg[i] <= cap_mag[i];
                        end
                        sgn_reg   <= cap_sgn;
                        mass_reg  <= s_data.mass;
                        last_reg  <= s_data.last_particle;
                        step_reg  <= '0;
                        state_reg <= ST_PART;
                    end
                end
                ST_PART: begin
                    step_reg <= (step_reg == 5'd17) ? '0 : step_reg + 5'd1;
                    unique case (step_reg)
                        5'd1: d2_reg <= prod_reg;
                        5'd2, 5'd3: d2_reg <= d2s65[64] ? '1 : d2s65[63:0];
                        5'd4: keep_reg <= !filt_reg || (d2_reg < prod_reg);
                        5'd5:  cx_reg <= pval;
                        5'd6:  cx_reg <= cx_reg - pval;
                        5'd7:  cy_reg <= pval;
                        5'd8:  cy_reg <= cy_reg - pval;
                        5'd9:  cz_reg <= pval;
                        5'd10: cz_reg <= cz_reg - pval;
                        5'd11: lo_reg <= prod_reg;
                        5'd12, 5'd14, 5'd16: term_reg <= tval;
                        5'd13: begin
                            lo_reg <= prod_reg;
                            if (keep_reg) sum_x_reg <= asum_new;
                        end
                        5'd15: begin
                            lo_reg <= prod_reg;
                            if (keep_reg) sum_y_reg <= asum_new;
                        end
                        5'd17: begin
                            if (keep_reg) begin
                                sum_z_reg    <= asum_new;
                                sum_mass_reg <= ms65[64] ? '1 : ms65[63:0];
                                if (count_reg != '1) count_reg <= count_reg + 32'd1;
                            end
                            sq_reg   <= '0;
                            if (!last_reg) begin
                                state_reg <= ST_IDLE;
                            end else if (keep_reg ? (ms65 == '0) : (sum_mass_reg == '0)) begin
                                state_reg <= ST_OUT;
                            end else begin
                                state_reg <= ST_SQ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_SQ: begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg != 5'd0) begin
                        sq_reg <= sq_reg + sq_add;
                    end
                    if (step_reg == 5'd12) begin
                        state_reg <= ST_ROOT;
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                    end
                end
                ST_ROOT: begin
                    sq_reg   <= {sq_reg[125:0], 2'b00};
                    rem_reg  <= rem_nx;
                    root_reg <= root_nx;
                    cnt_reg  <= (cnt_reg == CNT_W'(63)) ? '0 : cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(63)) begin
                        dvd_reg   <= {root_nx, {FRAC_BITS{1'b0}}};
                        drem_reg  <= '0;
                        q_reg     <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    drem_reg <= dge ? 64'(dr65 - {1'b0, sum_mass_reg}) : dr65[63:0];
                    q_reg    <= {q_reg[46:0], dge};
                    if (dge && (cnt_reg < CNT_W'(OVF_STEPS))) ovf_reg <= 1'b1;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DVD_W - 1)) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                 <= 1'b1;
                        m_data_reg.included_count   <= count_reg;
                        m_data_reg.no_mass          <= (sum_mass_reg == '0);
                        if (sum_mass_reg == '0) begin
                            m_data_reg.ang_mom_per_mass <= '0;
                        end else begin
                            m_data_reg.ang_mom_per_mass <= ovf_reg ? '1 : q_reg;
                        end
                        sum_x_reg    <= '0;
                        sum_y_reg    <= '0;
                        sum_z_reg    <= '0;
                        sum_mass_reg <= '0;
                        count_reg    <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SAM_ASSERT(a_accept_starts, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_PART && step_reg == 5'd0))
    `SAM_ASSERT(a_out_holds, aclk, aresetn, (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
    `SAM_NEVER(a_nomass_zero, aclk, aresetn, m_valid_reg && m_data_reg.no_mass && (m_data_reg.ang_mom_per_mass != '0))
endmodule
`default_nettype wire
